// ===== hw/rtl/swot_pkg.sv =====
// Shared constants, types and helpers for the sliding-window on/off time meter.
`timescale 1ns / 1ps
`default_nettype none

package swot_pkg;

    localparam int TIME_WIDTH       = 32;
    localparam int RING_DEPTH       = 1024;
    localparam int RING_INDEX_WIDTH = $clog2(RING_DEPTH);

    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_WIDTH  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

    localparam int STATUS_WIDTH     = 2;
    localparam int CFG_INDEX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH   = TIME_WIDTH;

    typedef logic [TIME_WIDTH-1:0]       time_t;
    typedef logic [RING_INDEX_WIDTH-1:0] ring_index_t;
    typedef logic [STATUS_WIDTH-1:0]     status_t;
    typedef logic [CFG_INDEX_WIDTH-1:0]  cfg_index_t;

    // Result status codes
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_BACKWARDS = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;

    // Register indexes
    localparam cfg_index_t REG_WINDOW_TICKS = 2'd0;
    localparam cfg_index_t REG_START_TIME   = 2'd1;
    localparam cfg_index_t REG_START_LEVEL  = 2'd2;

    localparam time_t WINDOW_RESET = TIME_WIDTH'(1000);

    typedef struct packed {
        time_t event_time;
        logic  level;
    } item_t;

    typedef struct packed {
        time_t window_ticks;
        time_t start_time;
        logic  start_level;
        logic  reload;
    } cfg_t;

    function automatic ring_index_t ring_next(input ring_index_t idx);
        if (idx == RING_INDEX_WIDTH'(RING_DEPTH - 1)) begin
            return '0;
        end
        return idx + ring_index_t'(1);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/swot_in_if.sv =====
// Input sample channel: timestamped level with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface swot_in_if;
    logic                  valid;
    logic                  ready;
    swot_pkg::time_t       event_time;
    logic                  level;

    modport source (output valid, output event_time, output level, input ready);
    modport sink   (input valid, input event_time, input level, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/swot_out_if.sv =====
// Result channel: on/off tick totals and status with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface swot_out_if;
    logic                  valid;
    logic                  ready;
    swot_pkg::time_t       on_ticks;
    swot_pkg::time_t       off_ticks;
    swot_pkg::status_t     status;

    modport source (output valid, output on_ticks, output off_ticks, output status,
                    input ready);
    modport sink   (input valid, input on_ticks, input off_ticks, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/swot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module swot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/swot_front.sv =====
// Front end: accept samples and hold them in a short queue for the back end.
`timescale 1ns / 1ps
`default_nettype none

module swot_front (
    input  wire logic      clk,
    input  wire logic      rst_n,
    swot_in_if.sink        sample,
    output swot_pkg::item_t q_item,
    output logic           q_valid,
    input  wire logic      q_pop
);

    localparam int PW = swot_pkg::QUEUE_PTR_WIDTH;
    localparam int CW = swot_pkg::QUEUE_CNT_WIDTH;

    swot_pkg::item_t slot_reg [swot_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(swot_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    assign sample.ready = (count_reg != CW'(swot_pkg::QUEUE_DEPTH));
    assign push         = sample.valid && sample.ready;
    assign q_valid      = (count_reg != '0);
    assign pop          = q_pop && q_valid;
    assign q_item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg].event_time <= sample.event_time;
            slot_reg[wr_ptr_reg].level      <= sample.level;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/swot_back.sv =====
// Back end: classify a queued sample, update totals, trim the ring tail.
`timescale 1ns / 1ps
`default_nettype none

module swot_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire swot_pkg::cfg_t  cfg,
    input  wire swot_pkg::item_t q_item,
    input  wire logic            q_valid,
    output logic                 q_pop,
    swot_out_if.source           result
);

    localparam int TW = swot_pkg::TIME_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TRIM = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0]            state_reg, state_next;
    swot_pkg::time_t       last_time_reg, last_time_next;
    swot_pkg::time_t       tail_time_reg, tail_time_next;
    swot_pkg::time_t       now_reg, now_next;
    swot_pkg::time_t       age_start_reg, age_start_next;
    swot_pkg::ring_index_t head_index_reg, head_index_next;
    swot_pkg::ring_index_t tail_index_reg, tail_index_next;
    logic                  head_level_reg, head_level_next;
    logic                  tail_level_reg, tail_level_next;
    swot_pkg::time_t       totals_reg [2];
    swot_pkg::time_t       totals_next [2];

    logic                  out_valid_reg, out_valid_next;
    swot_pkg::time_t       out_on_reg, out_on_next;
    swot_pkg::time_t       out_off_reg, out_off_next;
    swot_pkg::status_t     out_status_reg, out_status_next;

    logic                  emit;
    swot_pkg::status_t     emit_status;

    swot_pkg::time_t       delta;
    logic                  level_change;
    logic                  ring_full;
    logic                  start_ok;
    swot_pkg::time_t       age_start;
    swot_pkg::time_t       age_end;
    logic                  tail_has_next;

    logic                  ram_we;
    swot_pkg::ring_index_t ram_waddr;
    logic                  ram_re;
    swot_pkg::ring_index_t ram_raddr;
    swot_pkg::time_t       ram_rdata;

    swot_ram #(
        .WIDTH (TW),
        .DEPTH (swot_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_item.event_time),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign delta         = q_item.event_time - last_time_reg;
    assign level_change  = (q_item.level != head_level_reg);
    assign ring_full     = level_change &&
                           (swot_pkg::ring_next(head_index_reg) == tail_index_reg);
    assign start_ok      = (state_reg == ST_IDLE) && q_valid && !cfg.reload &&
                           (!out_valid_reg || result.ready);
    assign age_start     = now_reg - tail_time_reg;
    assign age_end       = now_reg - ram_rdata;
    assign tail_has_next = (tail_index_reg != head_index_reg);

    assign ram_waddr = swot_pkg::ring_next(head_index_reg);
    assign ram_raddr = swot_pkg::ring_next(tail_index_reg);

    always_comb
    begin
        state_next      = state_reg;
        last_time_next  = last_time_reg;
        tail_time_next  = tail_time_reg;
        now_next        = now_reg;
        age_start_next  = age_start_reg;
        head_index_next = head_index_reg;
        tail_index_next = tail_index_reg;
        head_level_next = head_level_reg;
        tail_level_next = tail_level_reg;
        totals_next[0]  = totals_reg[0];
        totals_next[1]  = totals_reg[1];
        out_valid_next  = out_valid_reg && !result.ready;
        out_on_next     = out_on_reg;
        out_off_next    = out_off_reg;
        out_status_next = out_status_reg;
        emit            = 1'b0;
        emit_status     = swot_pkg::STATUS_OK;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_ok)
                begin
                    q_pop = 1'b1;
                    if (delta[TW-1])
                    begin
                        emit        = 1'b1;
                        emit_status = swot_pkg::STATUS_BACKWARDS;
                    end
                    else if (ring_full)
                    begin
                        emit        = 1'b1;
                        emit_status = swot_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        totals_next[head_level_reg] = totals_reg[head_level_reg] + delta;
                        if (level_change)
                        begin
                            head_index_next = ram_waddr;
                            head_level_next = q_item.level;
                            ram_we          = 1'b1;
                        end
                        last_time_next = q_item.event_time;
                        now_next       = q_item.event_time;
                        state_next     = ST_TRIM;
                    end
                end
            end
            ST_TRIM:
            begin
                age_start_next = age_start;
                if (age_start <= cfg.window_ticks)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (tail_has_next)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EVAL;
                end
                else
                begin
                    // Cut the only segment at the window edge
                    totals_next[tail_level_reg] = totals_reg[tail_level_reg] -
                                                  (age_start - cfg.window_ticks);
                    tail_time_next = now_reg - cfg.window_ticks;
                    emit           = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                if (age_end >= cfg.window_ticks)
                begin
                    // Drop the whole oldest segment
                    totals_next[tail_level_reg] = totals_reg[tail_level_reg] -
                                                  (age_start_reg - age_end);
                    tail_index_next = ram_raddr;
                    tail_level_next = !tail_level_reg;
                    tail_time_next  = ram_rdata;
                    state_next      = ST_TRIM;
                end
                else
                begin
                    totals_next[tail_level_reg] = totals_reg[tail_level_reg] -
                                                  (age_start_reg - cfg.window_ticks);
                    tail_time_next = now_reg - cfg.window_ticks;
                    emit           = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_on_next     = totals_next[1];
            out_off_next    = totals_next[0];
            out_status_next = emit_status;
        end

        if (cfg.reload)
        begin
            state_next      = ST_IDLE;
            last_time_next  = cfg.start_time;
            tail_time_next  = cfg.start_time;
            head_index_next = '0;
            tail_index_next = '0;
            head_level_next = cfg.start_level;
            tail_level_next = cfg.start_level;
            totals_next[0]  = '0;
            totals_next[1]  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_time_reg  <= '0;
            tail_time_reg  <= '0;
            head_index_reg <= '0;
            tail_index_reg <= '0;
            head_level_reg <= 1'b0;
            tail_level_reg <= 1'b0;
            totals_reg[0]  <= '0;
            totals_reg[1]  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_time_reg  <= last_time_next;
            tail_time_reg  <= tail_time_next;
            head_index_reg <= head_index_next;
            tail_index_reg <= tail_index_next;
            head_level_reg <= head_level_next;
            tail_level_reg <= tail_level_next;
            totals_reg[0]  <= totals_next[0];
            totals_reg[1]  <= totals_next[1];
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        age_start_reg  <= age_start_next;
        out_on_reg     <= out_on_next;
        out_off_reg    <= out_off_next;
        out_status_reg <= out_status_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.on_ticks  = out_on_reg;
    assign result.off_ticks = out_off_reg;
    assign result.status    = out_status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_on_off_time.sv =====
// Top level of the sliding-window on/off time meter: configuration and wiring.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake     Payload
// sample    in   valid/ready   event_time[31:0], level
// result    out  valid/ready   on_ticks[31:0], off_ticks[31:0], status[1:0]
// cfg       in   cfg_we        cfg_index[1:0], cfg_data[31:0]
//
// A rejected sample is answered from idle; an accepted one goes through a
// trim step, plus a ring read and an evaluate step per old segment dropped
// from the ring tail; the oldest kept segment is cut in the evaluate step
// after such a read, or in the trim step if no later transition is stored.
// The ring memory has a single read port; each transition is dropped once,
// so the average stays small. The front queue holds two samples through result stalls.
// Reset is asynchronous and needs no clearing pass: the oldest transition
// time lives in a register and ring entries are read only after being written.
// Writing start_time or start_level reloads the measurement state.

module sliding_window_on_off_time (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    swot_in_if.sink                            sample,
    swot_out_if.source                         result,
    input  wire logic                          cfg_we,
    input  wire swot_pkg::cfg_index_t          cfg_index,
    input  wire logic [swot_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    // Configuration registers
    swot_pkg::time_t window_reg;
    swot_pkg::time_t start_time_reg;
    logic            start_level_reg;
    logic            reload_reg;

    swot_pkg::cfg_t  cfg;
    swot_pkg::item_t q_item;
    logic            q_valid;
    logic            q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= swot_pkg::WINDOW_RESET;
            start_time_reg  <= '0;
            start_level_reg <= 1'b0;
            reload_reg      <= 1'b0;
        end
        else
        begin
            // The reload pulse is registered in the same write as the start register,
            // so the back end sees the new start values.
            reload_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    swot_pkg::REG_WINDOW_TICKS:
                    begin
                        window_reg <= cfg_data[swot_pkg::TIME_WIDTH-1:0];
                    end
                    swot_pkg::REG_START_TIME:
                    begin
                        start_time_reg <= cfg_data[swot_pkg::TIME_WIDTH-1:0];
                        reload_reg     <= 1'b1;
                    end
                    swot_pkg::REG_START_LEVEL:
                    begin
                        start_level_reg <= cfg_data[0];
                        reload_reg      <= 1'b1;
                    end
                    default:
                    begin
                        // Drop writes to unmapped indexes
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.window_ticks = window_reg;
        cfg.start_time   = start_time_reg;
        cfg.start_level  = start_level_reg;
        cfg.reload       = reload_reg;
    end

    // Front end: accept samples into the queue
    swot_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    // Back end: classify, accumulate, trim and present results
    swot_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the sliding-window on/off time meter.
`timescale 1ns / 1ps

module tb;
    import swot_pkg::*;

    // Trimming the whole ring costs a read and an evaluate step per dropped entry,
    // and the long result hold-off stalls the block as well. Allow a wide margin.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 16;
    localparam int PLAN_ROWS      = 25;

    // cfg_index is two bits wide; the top code selects no register
    localparam cfg_index_t REG_UNUSED = 2'd3;

    typedef enum {PACE_TX30_RX66, PACE_TX66_RX30, PACE_STEADY} pace_t;
    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        time_t   on_ticks;
        time_t   off_ticks;
        status_t status;
    } window_tally_t;

    // One row of the directed part: a sample or a register write. Where typed is
    // set, want holds the result worked out by hand.
    typedef struct packed {
        row_kind_t     kind;
        cfg_index_t    index;
        time_t         value;
        logic          level;
        logic          typed;
        window_tally_t want;
    } plan_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    time_t      cfg_data;

    swot_in_if  sample_ch ();
    swot_out_if result_ch ();

    sliding_window_on_off_time DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Period 4 ns
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    pace_t         pace = PACE_TX30_RX66;
    logic          rx_hold = 1'b0;
    int            error_count = 0;
    int            quiet_cycles = 0;
    window_tally_t expected_tallies [$];
    window_tally_t rx_want;
    plan_row_t     plan [PLAN_ROWS];

    // Meter state as the block should hold it
    time_t       meter_window;
    time_t       meter_start_time;
    logic        meter_start_level;
    time_t       meter_last;
    time_t       flip_times [RING_DEPTH];
    ring_index_t newest;
    ring_index_t oldest;
    logic        newest_level;
    logic        oldest_level;
    time_t       level_sum [2];

    task automatic flag_error(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Restart measurement from the start registers.
    function automatic void reload_meter();
        foreach (flip_times[i])
            flip_times[i] = '0;
        meter_last    = meter_start_time;
        flip_times[0] = meter_start_time;
        newest        = '0;
        oldest        = '0;
        newest_level  = meter_start_level;
        oldest_level  = meter_start_level;
        level_sum[0]  = '0;
        level_sum[1]  = '0;
    endfunction

    function automatic void apply_write(input cfg_index_t idx, input time_t value);
        case (idx)
            REG_WINDOW_TICKS: meter_window = value;
            REG_START_TIME:
            begin
                meter_start_time = value;
                reload_meter();
            end
            REG_START_LEVEL:
            begin
                meter_start_level = value[0];
                reload_meter();
            end
            default: ;
        endcase
    endfunction

    // Drop segments that ended at or before now - window; cut the oldest survivor at
    // the window edge. The ring is a power of two deep, so indexes wrap by
    // themselves.
    function automatic void trim_window(input time_t now);
        time_t age_start;
        time_t age_end;
        for (int n = 0; n <= RING_DEPTH; n++)
        begin
            age_start = now - flip_times[oldest];
            if (age_start <= meter_window)
                break;
            age_end = '0;
            if (oldest != newest)
                age_end = now - flip_times[ring_index_t'(oldest + 1'b1)];
            if (oldest != newest && age_end >= meter_window)
            begin
                level_sum[oldest_level] -= age_start - age_end;
                oldest       += 1'b1;
                oldest_level = ~oldest_level;
            end
            else
            begin
                level_sum[oldest_level] -= age_start - meter_window;
                flip_times[oldest] = now - meter_window;
                break;
            end
        end
    endfunction

    // Account one sample and return the tally the block should report for it.
    function automatic window_tally_t advance_meter(input time_t now, input logic lvl);
        time_t         step;
        window_tally_t tally;
        step = now - meter_last;
        tally.status = STATUS_OK;
        if (step[TIME_WIDTH-1])
            tally.status = STATUS_BACKWARDS;
        else if (lvl != newest_level && ring_index_t'(newest + 1'b1) == oldest)
            tally.status = STATUS_FULL;
        else
        begin
            level_sum[newest_level] += step;
            if (lvl != newest_level)
            begin
                newest += 1'b1;
                flip_times[newest] = now;
                newest_level = lvl;
            end
            meter_last = now;
            trim_window(now);
        end
        tally.on_ticks  = level_sum[1];
        tally.off_ticks = level_sum[0];
        return tally;
    endfunction

    function automatic bit sender_idles();
        case (pace)
            PACE_TX30_RX66: return $urandom_range(0, 99) < 30;
            PACE_TX66_RX30: return $urandom_range(0, 99) < 66;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_takes();
        case (pace)
            PACE_TX30_RX66: return $urandom_range(0, 99) >= 66;
            PACE_TX66_RX30: return $urandom_range(0, 99) >= 30;
            default:        return 1'b1;
        endcase
    endfunction

    // Offer one sample and hold it until accepted. Valid stays high afterwards,
    // so back-to-back items need no extra edge; the next idle or write drops it.
    task automatic send_sample(input time_t t, input logic lvl, input logic typed,
                               input window_tally_t want);
        window_tally_t predicted;
        while (sender_idles())
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid      <= 1'b1;
        sample_ch.event_time <= t;
        sample_ch.level      <= lvl;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predicted = advance_meter(t, lvl);
        expected_tallies.push_back(typed ? want : predicted);
    endtask

    // Write a register once the block has drained.
    task automatic write_reg(input cfg_index_t idx, input time_t value);
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_tallies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_write(idx, value);
    endtask

    // Mostly forward steps with random level flips; a few big jumps, and a few
    // samples that go back in time and must be rejected.
    task automatic run_random(input int count, input int unsigned step_max);
        time_t       t;
        time_t       probe;
        logic        lvl;
        int unsigned pick;
        t   = meter_last;
        lvl = newest_level;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                probe = t - time_t'($urandom_range(1, 1000));
                send_sample(probe, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
            else if (pick < 7)
            begin
                probe = t + 32'h8000_0000 + time_t'($urandom_range(0, 32'h7FFF_FFFF));
                send_sample(probe, 1'($urandom_range(0, 1)), 1'b0, '0);
            end
            else
            begin
                if (pick < 10)
                    t += time_t'($urandom_range(0, 32'h7FFF_FFFF));
                else
                    t += time_t'($urandom_range(0, step_max));
                if ($urandom_range(0, 1) != 0)
                    lvl = ~lvl;
                send_sample(t, lvl, 1'b0, '0);
            end
        end
    endtask

    // Check every accepted result against the oldest expectation, then pick
    // ready for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_tallies.size() == 0)
                flag_error($sformatf("unexpected result on=%0d off=%0d status=%0d",
                                     result_ch.on_ticks, result_ch.off_ticks,
                                     result_ch.status));
            else
            begin
                rx_want = expected_tallies.pop_front();
                if (result_ch.on_ticks !== rx_want.on_ticks)
                    flag_error($sformatf("on_ticks got %0d want %0d",
                                         result_ch.on_ticks, rx_want.on_ticks));
                if (result_ch.off_ticks !== rx_want.off_ticks)
                    flag_error($sformatf("off_ticks got %0d want %0d",
                                         result_ch.off_ticks, rx_want.off_ticks));
                if (result_ch.status !== rx_want.status)
                    flag_error($sformatf("status got %0d want %0d",
                                         result_ch.status, rx_want.status));
            end
        end
        result_ch.ready <= !rx_hold && receiver_takes();
    end

    // End the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sliding_window_on_off_time: mismatch");
            $finish;
        end
    end

    initial
    begin
        time_t t;
        logic  lvl;

        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_WINDOW_TICKS;
        cfg_data             = '0;
        sample_ch.valid      = 1'b0;
        sample_ch.event_time = '0;
        sample_ch.level      = 1'b0;
        result_ch.ready      = 1'b0;

        meter_window      = WINDOW_RESET;
        meter_start_time  = '0;
        meter_start_level = 1'b0;
        reload_meter();

        // Directed part: reset values, equal and backward time, window cut,
        // reload through both start registers, zero and full-range windows,
        // the unused register code, and drop at the exact window edge.
        plan = '{
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd0,         1'b0, 1'b1, '{32'd0,   32'd0,   STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd100,       1'b1, 1'b1, '{32'd0,   32'd100, STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd50,        1'b0, 1'b1,
              '{32'd0, 32'd100, STATUS_BACKWARDS}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd100,       1'b1, 1'b1, '{32'd0,   32'd100, STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd600,       1'b0, 1'b1, '{32'd500, 32'd100, STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd1300,      1'b0, 1'b1, '{32'd300, 32'd700, STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'h8000_0514, 1'b1, 1'b1,
              '{32'd300, 32'd700, STATUS_BACKWARDS}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'h8000_0513, 1'b1, 1'b0, '0},
            '{ROW_WRITE,  REG_START_TIME,   32'hFFFF_FFF0, 1'b0, 1'b0, '0},
            '{ROW_WRITE,  REG_START_LEVEL,  32'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'hFFFF_FFFF, 1'b1, 1'b1, '{32'd15,  32'd0,   STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd5,         1'b0, 1'b1, '{32'd21,  32'd0,   STATUS_OK}},
            '{ROW_WRITE,  REG_WINDOW_TICKS, 32'd0,         1'b0, 1'b0, '0},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd5,         1'b0, 1'b1, '{32'd0,   32'd0,   STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'd9,         1'b1, 1'b1, '{32'd0,   32'd0,   STATUS_OK}},
            '{ROW_WRITE,  REG_WINDOW_TICKS, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'h7FFF_FFFF, 1'b1, 1'b0, '0},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'hFFFF_FFFE, 1'b1, 1'b0, '0},
            '{ROW_WRITE,  REG_UNUSED,       32'h0000_1234, 1'b0, 1'b0, '0},
            '{ROW_WRITE,  REG_WINDOW_TICKS, 32'd1,         1'b0, 1'b0, '0},
            '{ROW_WRITE,  REG_START_LEVEL,  32'd0,         1'b0, 1'b0, '0},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'hFFFF_FFF3, 1'b0, 1'b1, '{32'd0,   32'd1,   STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'hFFFF_FFF3, 1'b1, 1'b1, '{32'd0,   32'd1,   STATUS_OK}},
            '{ROW_SAMPLE, REG_WINDOW_TICKS, 32'hFFFF_FFF4, 1'b1, 1'b1, '{32'd1,   32'd0,   STATUS_OK}}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
                write_reg(plan[i].index, plan[i].value);
            else
                send_sample(plan[i].value, plan[i].level, plan[i].typed, plan[i].want);
        end

        // Short windows: nearly every sample trims the tail.
        write_reg(REG_WINDOW_TICKS, time_t'($urandom_range(1, 40)));
        write_reg(REG_START_TIME, time_t'($urandom));
        write_reg(REG_START_LEVEL, time_t'($urandom));
        run_random(250, 16);

        // Swap the idling: slow sender, eager receiver; medium windows.
        pace = PACE_TX66_RX30;
        write_reg(REG_START_LEVEL, time_t'($urandom));
        write_reg(REG_WINDOW_TICKS, time_t'($urandom_range(500, 3000)));
        write_reg(REG_START_TIME, time_t'($urandom));
        run_random(250, 300);

        // No idling. With the full-range window nothing ever leaves the ring,
        // so a run of flips fills it; hold results off meanwhile so the block
        // backs up and stalls its input.
        pace = PACE_STEADY;
        write_reg(REG_WINDOW_TICKS, 32'hFFFF_FFFF);
        write_reg(REG_START_TIME, time_t'($urandom));
        write_reg(REG_START_LEVEL, time_t'($urandom));
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        t   = meter_last;
        lvl = newest_level;
        for (int i = 0; i < RING_DEPTH - 1; i++)
        begin
            t += time_t'($urandom_range(0, 3));
            lvl = ~lvl;
            send_sample(t, lvl, 1'b0, '0);
        end
        // Ring is full: flips are refused, same-level samples still pass.
        for (int i = 0; i < 6; i++)
        begin
            t += time_t'($urandom_range(0, 3));
            send_sample(t, (i % 2 == 0) ? ~lvl : lvl, 1'b0, '0);
        end

        // Shrink the window: the next sample drops almost the whole ring.
        write_reg(REG_WINDOW_TICKS, 32'd300);
        run_random(250, 20);

        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_tallies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sliding_window_on_off_time: match");
        else
            $display("sliding_window_on_off_time: mismatch");
        $finish;
    end

endmodule
